// ===== rtl/core/nnds_pkg.sv =====
// ----------------------------------------------------------------------------
// nnds_pkg: shared definitions for the nearest-neighbour downscaler
// Widths, register indexes, reset values and the tag passed from the
// position walk to the pixel datapath.
// ----------------------------------------------------------------------------
package nnds_pkg;

  // Largest supported frame dimension in pixels.
  localparam int unsigned MAX_DIM = 4096;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIM_REG_W  = 13;

  // Pixel fields.
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned DEPTH_W  = 24;
  localparam int unsigned SCALE_W  = 24;

  // Depth multiply, split into two partial products on the depth sample.
  localparam int unsigned DEPTH_SPLIT = 12;
  localparam int unsigned PP_W        = DEPTH_SPLIT + SCALE_W;
  localparam int unsigned PROD_W      = DEPTH_W + SCALE_W;
  localparam int unsigned GREY_SHIFT  = 28;

  // Reset values of the configuration registers.
  localparam logic [DIM_REG_W-1:0] SRC_WIDTH_RST  = DIM_REG_W'(640);
  localparam logic [DIM_REG_W-1:0] SRC_HEIGHT_RST = DIM_REG_W'(480);
  localparam logic [DIM_REG_W-1:0] DST_WIDTH_RST  = DIM_REG_W'(640);
  localparam logic [DIM_REG_W-1:0] DST_HEIGHT_RST = DIM_REG_W'(480);
  localparam logic [SCALE_W-1:0]   DEPTH_SCALE_RST = SCALE_W'(65536);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_WIDTH   = 3'd2,
    REG_DST_HEIGHT  = 3'd3,
    REG_FORMAT_MODE = 3'd4,
    REG_DEPTH_SCALE = 3'd5
  } nnds_reg_e;

  // Per-beat decision from the position walk.
  typedef struct packed {
    logic take;   // source pixel lands on the destination grid
    logic last;   // final destination pixel of the frame
  } nnds_tag_t;

endpackage

// ===== rtl/core/nnds_if.sv =====
// ----------------------------------------------------------------------------
// nnds_if: stream and configuration interfaces of the downscaler
// Source pixel stream, result pixel stream and register write channel.
// ----------------------------------------------------------------------------

// Source pixel stream.
interface nnds_pix_if;
  logic                           valid;
  logic                           ready;
  logic [nnds_pkg::COLOUR_W-1:0]  blue_in;
  logic [nnds_pkg::COLOUR_W-1:0]  green_in;
  logic [nnds_pkg::COLOUR_W-1:0]  red_in;
  logic [nnds_pkg::DEPTH_W-1:0]   depth_in;

  modport source (output valid, blue_in, green_in, red_in, depth_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, depth_in, output ready);
endinterface

// Result pixel stream.
interface nnds_res_if;
  logic                           valid;
  logic                           ready;
  logic [nnds_pkg::COLOUR_W-1:0]  red_out;
  logic [nnds_pkg::COLOUR_W-1:0]  green_out;
  logic [nnds_pkg::COLOUR_W-1:0]  blue_out;
  logic                           frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// Register write channel.
interface nnds_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nnds_pkg::CFG_IDX_W-1:0]  index;
  logic [nnds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/nnds_cfg.sv =====
// ----------------------------------------------------------------------------
// nnds_cfg: configuration registers and effective frame sizes
// Holds the six registers, clamps the sizes and flags a frame restart on
// every write to a defined register.
// ----------------------------------------------------------------------------
module nnds_cfg #(
  parameter int unsigned MaxDim = nnds_pkg::MAX_DIM,
  parameter int unsigned DimW   = $clog2(MaxDim + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nnds_cfg_if.sink                     cfg_i,
  output logic [DimW-1:0]              src_w_o,
  output logic [DimW-1:0]              src_h_o,
  output logic [DimW-1:0]              dst_w_o,
  output logic [DimW-1:0]              dst_h_o,
  output logic                         depth_mode_o,
  output logic [nnds_pkg::SCALE_W-1:0] depth_scale_o,
  output logic                         restart_o
);

  localparam int unsigned CmpW =
    (DimW > nnds_pkg::DIM_REG_W) ? DimW : nnds_pkg::DIM_REG_W;

  logic [nnds_pkg::DIM_REG_W-1:0] src_width_q, src_width_d;
  logic [nnds_pkg::DIM_REG_W-1:0] src_height_q, src_height_d;
  logic [nnds_pkg::DIM_REG_W-1:0] dst_width_q, dst_width_d;
  logic [nnds_pkg::DIM_REG_W-1:0] dst_height_q, dst_height_d;
  logic                           format_mode_q, format_mode_d;
  logic [nnds_pkg::SCALE_W-1:0]   depth_scale_q, depth_scale_d;
  logic                           wr_en;
  logic [CmpW-1:0]                max_c, sw_c, sh_c, dw_c, dh_c;
  logic [CmpW-1:0]                sw_eff, sh_eff, dw_eff, dh_eff;

  // The channel never stalls.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  // Register write decode. An index past the list is ignored.
  always_comb begin
    src_width_d   = src_width_q;
    src_height_d  = src_height_q;
    dst_width_d   = dst_width_q;
    dst_height_d  = dst_height_q;
    format_mode_d = format_mode_q;
    depth_scale_d = depth_scale_q;
    restart_o     = 1'b0;
    if (wr_en) begin
      restart_o = 1'b1;
      unique case (nnds_pkg::nnds_reg_e'(cfg_i.index))
        nnds_pkg::REG_SRC_WIDTH:   src_width_d   = cfg_i.data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_SRC_HEIGHT:  src_height_d  = cfg_i.data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_DST_WIDTH:   dst_width_d   = cfg_i.data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_DST_HEIGHT:  dst_height_d  = cfg_i.data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_FORMAT_MODE: format_mode_d = cfg_i.data[0];
        nnds_pkg::REG_DEPTH_SCALE: depth_scale_d = cfg_i.data[nnds_pkg::SCALE_W-1:0];
        default:                   restart_o     = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= nnds_pkg::SRC_WIDTH_RST;
      src_height_q  <= nnds_pkg::SRC_HEIGHT_RST;
      dst_width_q   <= nnds_pkg::DST_WIDTH_RST;
      dst_height_q  <= nnds_pkg::DST_HEIGHT_RST;
      format_mode_q <= 1'b0;
      depth_scale_q <= nnds_pkg::DEPTH_SCALE_RST;
    end else begin
      src_width_q   <= src_width_d;
      src_height_q  <= src_height_d;
      dst_width_q   <= dst_width_d;
      dst_height_q  <= dst_height_d;
      format_mode_q <= format_mode_d;
      depth_scale_q <= depth_scale_d;
    end
  end

  // Clamp the source sizes to 1..MaxDim and the destination sizes to
  // 1..source size.
  always_comb begin
    max_c  = CmpW'(MaxDim);
    sw_c   = CmpW'(src_width_q);
    sh_c   = CmpW'(src_height_q);
    dw_c   = CmpW'(dst_width_q);
    dh_c   = CmpW'(dst_height_q);
    sw_eff = (sw_c == '0) ? CmpW'(1) : ((sw_c > max_c) ? max_c : sw_c);
    sh_eff = (sh_c == '0) ? CmpW'(1) : ((sh_c > max_c) ? max_c : sh_c);
    dw_eff = (dw_c == '0) ? CmpW'(1) : ((dw_c > sw_eff) ? sw_eff : dw_c);
    dh_eff = (dh_c == '0) ? CmpW'(1) : ((dh_c > sh_eff) ? sh_eff : dh_c);
  end

  assign src_w_o       = sw_eff[DimW-1:0];
  assign src_h_o       = sh_eff[DimW-1:0];
  assign dst_w_o       = dw_eff[DimW-1:0];
  assign dst_h_o       = dh_eff[DimW-1:0];
  assign depth_mode_o  = format_mode_q;
  assign depth_scale_o = depth_scale_q;

endmodule

// ===== rtl/core/nnds_walk.sv =====
// ----------------------------------------------------------------------------
// nnds_walk: source position tracker and grid selection
// Follows the raster position of the source stream and decides, by an
// integer error walk, which source pixels land on the destination grid.
// ----------------------------------------------------------------------------
module nnds_walk #(
  parameter int unsigned DimW = $clog2(nnds_pkg::MAX_DIM + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic                accept_i,
  input  logic [DimW-1:0]     src_w_i,
  input  logic [DimW-1:0]     src_h_i,
  input  logic [DimW-1:0]     dst_w_i,
  input  logic [DimW-1:0]     dst_h_i,
  output nnds_pkg::nnds_tag_t tag_o
);

  // Error terms are kept relative to their start value, so that a restart
  // clears them to zero whatever the sizes.
  localparam int unsigned ErrW = DimW + 2;

  logic [DimW-1:0]        src_col_q, src_col_d;
  logic [DimW-1:0]        src_row_q, src_row_d;
  logic [DimW-1:0]        out_col_q, out_col_d;
  logic [DimW-1:0]        out_row_q, out_row_d;
  logic signed [ErrW-1:0] col_err_q, col_err_d;
  logic signed [ErrW-1:0] row_err_q, row_err_d;

  logic signed [ErrW-1:0] w_s, h_s, w2_s, h2_s, sw2_s, sh2_s;
  logic signed [ErrW-1:0] col_step, row_step;
  logic                   col_sel, row_sel, take, row_end, frame_end;

  // Sizes as signed error-walk quantities.
  assign w_s   = $signed({2'b00, dst_w_i});
  assign h_s   = $signed({2'b00, dst_h_i});
  assign w2_s  = $signed({1'b0, dst_w_i, 1'b0});
  assign h2_s  = $signed({1'b0, dst_h_i, 1'b0});
  assign sw2_s = $signed({1'b0, src_w_i, 1'b0});
  assign sh2_s = $signed({1'b0, src_h_i, 1'b0});

  // Grid selection for the current source pixel.
  assign col_sel = (out_col_q < dst_w_i) && (col_err_q >= -w_s) && (col_err_q < w_s);
  assign row_sel = (out_row_q < dst_h_i) && (row_err_q >= -h_s) && (row_err_q < h_s);
  assign take    = col_sel && row_sel;

  assign row_end   = ({1'b0, src_col_q} + (DimW+1)'(1)) >= {1'b0, src_w_i};
  assign frame_end = ({1'b0, src_row_q} + (DimW+1)'(1)) >= {1'b0, src_h_i};

  assign col_step = take ? (sw2_s - w2_s) : -w2_s;
  assign row_step = row_sel ? (sh2_s - h2_s) : -h2_s;

  assign tag_o.take = take;
  assign tag_o.last = (out_row_q == (dst_h_i - DimW'(1))) &&
                      (out_col_q == (dst_w_i - DimW'(1)));

  // Position update on each accepted beat; a register write restarts the frame.
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    col_err_d = col_err_q;
    row_err_d = row_err_q;
    if (restart_i) begin
      src_col_d = '0;
      src_row_d = '0;
      out_col_d = '0;
      out_row_d = '0;
      col_err_d = '0;
      row_err_d = '0;
    end else if (accept_i) begin
      if (row_end) begin
        src_col_d = '0;
        out_col_d = '0;
        col_err_d = '0;
        if (frame_end) begin
          src_row_d = '0;
          out_row_d = '0;
          row_err_d = '0;
        end else begin
          src_row_d = src_row_q + DimW'(1);
          out_row_d = out_row_q + DimW'(row_sel);
          row_err_d = row_err_q + row_step;
        end
      end else begin
        src_col_d = src_col_q + DimW'(1);
        out_col_d = out_col_q + DimW'(take);
        col_err_d = col_err_q + col_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      col_err_q <= '0;
      row_err_q <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      col_err_q <= col_err_d;
      row_err_q <= row_err_d;
    end
  end

`ifndef ASSERT_OFF
  // The destination column count never passes the destination width.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_col_q <= dst_w_i)
    else $error("nnds_walk: destination column beyond width");

  // The source column always stays inside the source row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) src_col_q < src_w_i)
    else $error("nnds_walk: source column beyond width");

  // A register write leaves the walk at the start of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (src_col_q == '0) && (src_row_q == '0) && (out_row_q == '0))
    else $error("nnds_walk: frame not restarted after register write");

  // The row selection is stable within a source row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !restart_i && !row_end) |=> $stable(row_err_q) && $stable(out_row_q))
    else $error("nnds_walk: row state changed inside a row");
`endif

endmodule

// ===== rtl/core/nnds_pipe.sv =====
// ----------------------------------------------------------------------------
// nnds_pipe: pixel datapath with input and result registers
// Registers the selected pixels with the depth partial products, then forms
// the RGB result in the output register.
// ----------------------------------------------------------------------------
module nnds_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nnds_pix_if.sink                     pix_i,
  nnds_res_if.source                   res_o,
  input  nnds_pkg::nnds_tag_t          tag_i,
  input  logic                         depth_mode_i,
  input  logic [nnds_pkg::SCALE_W-1:0] depth_scale_i,
  output logic                         accept_o
);

  localparam int unsigned CW = nnds_pkg::COLOUR_W;
  localparam int unsigned PW = nnds_pkg::PP_W;
  localparam int unsigned SW = nnds_pkg::PROD_W;
  localparam int unsigned DS = nnds_pkg::DEPTH_SPLIT;
  localparam int unsigned GS = nnds_pkg::GREY_SHIFT;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_last_q;
  logic [CW-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [PW-1:0] s1_pp_lo_q, s1_pp_hi_q;
  logic          out_valid_q, out_valid_d;
  logic          out_last_q;
  logic [CW-1:0] out_red_q, out_green_q, out_blue_q;

  logic          out_free, advance, load;
  logic [SW-1:0] prod;
  logic [CW-1:0] grey;

  // Handshake: the input stage moves on whenever the result register is
  // free or being emptied this cycle.
  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign pix_i.ready = !s1_valid_q || out_free;
  assign accept_o    = pix_i.valid && pix_i.ready;
  assign load        = accept_o && tag_i.take;

  assign s1_valid_d  = load ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: colour bytes and the two depth partial products.
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_last_q  <= tag_i.last;
      s1_red_q   <= pix_i.red_in;
      s1_green_q <= pix_i.green_in;
      s1_blue_q  <= pix_i.blue_in;
      s1_pp_lo_q <= PW'(pix_i.depth_in[DS-1:0]) * PW'(depth_scale_i);
      s1_pp_hi_q <= PW'(pix_i.depth_in[nnds_pkg::DEPTH_W-1:DS]) * PW'(depth_scale_i);
    end
  end

  // Depth to grey: sum the partial products, drop the fraction, saturate.
  assign prod = (SW'(s1_pp_hi_q) << DS) + SW'(s1_pp_lo_q);
  assign grey = (|prod[SW-1:GS+CW]) ? {CW{1'b1}} : prod[GS+CW-1:GS];

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_last_q  <= s1_last_q;
      out_red_q   <= depth_mode_i ? grey : s1_red_q;
      out_green_q <= depth_mode_i ? grey : s1_green_q;
      out_blue_q  <= depth_mode_i ? grey : s1_blue_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.red_out    = out_red_q;
  assign res_o.green_out  = out_green_q;
  assign res_o.blue_out   = out_blue_q;
  assign res_o.frame_last = out_last_q;

`ifndef ASSERT_OFF
  // A held pixel in the input register is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |-> !load)
    else $error("nnds_pipe: input register overwritten while stalled");

  // A stalled input stage keeps its pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_last_q))
    else $error("nnds_pipe: stalled pixel lost");

  // A result is only produced from an occupied input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("nnds_pipe: result without a pixel");
`endif

endmodule

// ===== rtl/core/nearest_neighbor_downscaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler: nearest-neighbour frame downscaler
// Takes source pixels in raster order and emits the RGB pixels that fall on
// the destination grid, in colour (BGR reorder) or depth (scaled grey) mode.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat carries
//   cfg_i     in         register index, write data
//   pix_i     in         blue_in, green_in, red_in, depth_in
//   res_o     out        red_out, green_out, blue_out, frame_last
//
// One source beat is taken every cycle while pix_i is not stalled; a kept pixel reaches
// res_o through the input register, then the result register.
// The depth multiply is split into two partial products in the input stage
// and summed in front of the result register.
// A stall on res_o fills the input register; pix_i then stalls too.
// Reset returns the registers to their defaults and the walk to frame start;
// any write to a defined register also restarts the frame.
module nearest_neighbor_downscaler #(
  parameter int unsigned MaxDim = nnds_pkg::MAX_DIM
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nnds_cfg_if.sink   cfg_i,
  nnds_pix_if.sink   pix_i,
  nnds_res_if.source res_o
);

  localparam int unsigned DimW = $clog2(MaxDim + 1);

  logic [DimW-1:0]              src_w, src_h, dst_w, dst_h;
  logic                         depth_mode;
  logic [nnds_pkg::SCALE_W-1:0] depth_scale;
  logic                         restart;
  logic                         accept;
  nnds_pkg::nnds_tag_t          tag;

  // Register file and size clamping.
  nnds_cfg #(
    .MaxDim (MaxDim),
    .DimW   (DimW)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .src_w_o       (src_w),
    .src_h_o       (src_h),
    .dst_w_o       (dst_w),
    .dst_h_o       (dst_h),
    .depth_mode_o  (depth_mode),
    .depth_scale_o (depth_scale),
    .restart_o     (restart)
  );

  // Raster position and grid selection.
  nnds_walk #(
    .DimW (DimW)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .accept_i  (accept),
    .src_w_i   (src_w),
    .src_h_i   (src_h),
    .dst_w_i   (dst_w),
    .dst_h_i   (dst_h),
    .tag_o     (tag)
  );

  // Pixel datapath.
  nnds_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_i),
    .res_o         (res_o),
    .tag_i         (tag),
    .depth_mode_i  (depth_mode),
    .depth_scale_i (depth_scale),
    .accept_o      (accept)
  );

endmodule

// ===== verif/nearest_neighbor_downscaler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_test: self-checking bench for the downscaler
// Streams raster-order source beats through the block under a series of
// register settings and checks every result beat against a bit-exact
// prediction of the column and row error walk and the colour/depth datapath.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler_test;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned MAX_GAP      = 19;

  // Indexes past the last register; writes there must be ignored.
  localparam logic [nnds_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [nnds_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Largest value a size register can hold.
  localparam logic [nnds_pkg::DIM_REG_W-1:0] DIM_MAX_WORD = '1;

  typedef struct packed {
    logic [nnds_pkg::COLOUR_W-1:0] blue;
    logic [nnds_pkg::COLOUR_W-1:0] green;
    logic [nnds_pkg::COLOUR_W-1:0] red;
    logic [nnds_pkg::DEPTH_W-1:0]  depth;
  } src_pixel_t;

  typedef struct packed {
    logic [nnds_pkg::COLOUR_W-1:0] red;
    logic [nnds_pkg::COLOUR_W-1:0] green;
    logic [nnds_pkg::COLOUR_W-1:0] blue;
    logic                          last;
  } rgb_pixel_t;

  // Predicts which source beats land on the destination grid and holds the
  // resulting pixels until the block delivers them.
  class downscale_scoreboard;
    logic [nnds_pkg::DIM_REG_W-1:0] src_width;
    logic [nnds_pkg::DIM_REG_W-1:0] src_height;
    logic [nnds_pkg::DIM_REG_W-1:0] dst_width;
    logic [nnds_pkg::DIM_REG_W-1:0] dst_height;
    logic                           format_mode;
    logic [nnds_pkg::SCALE_W-1:0]   depth_scale;
    int                             src_col;
    int                             src_row;
    int                             out_col;
    int                             out_row;
    int                             col_error;
    int                             row_error;
    rgb_pixel_t                     expected_pixels[$];
    int unsigned                    fail_count;
    int unsigned                    checked_count;
    int unsigned                    frame_ends;

    function new();
      fail_count    = 0;
      checked_count = 0;
      frame_ends    = 0;
      restore_defaults();
    endfunction

    function void restore_defaults();
      src_width   = nnds_pkg::SRC_WIDTH_RST;
      src_height  = nnds_pkg::SRC_HEIGHT_RST;
      dst_width   = nnds_pkg::DST_WIDTH_RST;
      dst_height  = nnds_pkg::DST_HEIGHT_RST;
      format_mode = 1'b0;
      depth_scale = nnds_pkg::DEPTH_SCALE_RST;
      restart_walk();
    endfunction

    function int clamp_size(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int frame_w();
      return clamp_size(int'(src_width), int'(nnds_pkg::MAX_DIM));
    endfunction

    function int frame_h();
      return clamp_size(int'(src_height), int'(nnds_pkg::MAX_DIM));
    endfunction

    function int grid_w();
      return clamp_size(int'(dst_width), frame_w());
    endfunction

    function int grid_h();
      return clamp_size(int'(dst_height), frame_h());
    endfunction

    // Back to the top-left corner of a frame with the current sizes.
    function void restart_walk();
      src_col   = 0;
      src_row   = 0;
      out_col   = 0;
      out_row   = 0;
      col_error = grid_w();
      row_error = grid_h();
    endfunction

    // Any write to a known register restarts the frame.
    function void write_reg(logic [nnds_pkg::CFG_IDX_W-1:0] idx,
                            logic [nnds_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nnds_pkg::REG_SRC_WIDTH:   src_width   = data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_SRC_HEIGHT:  src_height  = data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_DST_WIDTH:   dst_width   = data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_DST_HEIGHT:  dst_height  = data[nnds_pkg::DIM_REG_W-1:0];
        nnds_pkg::REG_FORMAT_MODE: format_mode = data[0];
        nnds_pkg::REG_DEPTH_SCALE: depth_scale = data[nnds_pkg::SCALE_W-1:0];
        default:                   return;
      endcase
      restart_walk();
    endfunction

    // Advances the walk by one accepted source beat.
    function void note_source_pixel(src_pixel_t px);
      int                                                sw;
      int                                                sh;
      int                                                dw;
      int                                                dh;
      bit                                                row_hit;
      bit                                                col_hit;
      logic [nnds_pkg::PROD_W-1:0]                       product;
      logic [nnds_pkg::PROD_W-nnds_pkg::GREY_SHIFT-1:0]  grey;
      rgb_pixel_t                                        want;
      sw = frame_w();
      sh = frame_h();
      dw = grid_w();
      dh = grid_h();
      row_hit = (out_row < dh) && (row_error >= 0) && (row_error < 2 * dh);
      col_hit = (out_col < dw) && (col_error >= 0) && (col_error < 2 * dw);

      // Kept pixel: reorder the colour bytes, or scale and saturate depth.
      if (row_hit && col_hit) begin
        if (format_mode) begin
          product    = nnds_pkg::PROD_W'(px.depth) * nnds_pkg::PROD_W'(depth_scale);
          grey       = product[nnds_pkg::PROD_W-1:nnds_pkg::GREY_SHIFT];
          want.red   = (grey > 255) ? 8'hFF : grey[nnds_pkg::COLOUR_W-1:0];
          want.green = want.red;
          want.blue  = want.red;
        end else begin
          want.red   = px.red;
          want.green = px.green;
          want.blue  = px.blue;
        end
        want.last = (out_row == dh - 1) && (out_col == dw - 1);
        expected_pixels.push_back(want);
        out_col++;
        col_error += 2 * sw;
      end
      col_error -= 2 * dw;

      // End of a source row, and possibly of the frame.
      if (src_col + 1 >= sw) begin
        src_col   = 0;
        out_col   = 0;
        col_error = dw;
        if (row_hit) begin
          out_row++;
          row_error += 2 * sh;
        end
        row_error -= 2 * dh;
        if (src_row + 1 >= sh) begin
          src_row   = 0;
          out_row   = 0;
          row_error = dh;
        end else begin
          src_row++;
        end
      end else begin
        src_col++;
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_output_pixel(logic [nnds_pkg::COLOUR_W-1:0] r,
                                     logic [nnds_pkg::COLOUR_W-1:0] g,
                                     logic [nnds_pkg::COLOUR_W-1:0] b, logic l);
      rgb_pixel_t want;
      checked_count++;
      if (l === 1'b1) frame_ends++;
      if (expected_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected output pixel, expected none,", $time,
                 " actual r=%0d g=%0d b=%0d last=%0d", r, g, b, l);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red_out", want.red, r);
      compare_field("green_out", want.green, g);
      compare_field("blue_out", want.blue, b);
      compare_field("frame_last", want.last, l);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nnds_cfg_if cfg ();
  nnds_pix_if pix ();
  nnds_res_if res ();

  nearest_neighbor_downscaler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .res_o  (res)
  );

  downscale_scoreboard sb;
  bit                  rx_idle;
  bit                  hold_req;
  int unsigned         beats_sent;
  int unsigned         settings_count;
  int unsigned         cycle_count;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached with %0d pixels outstanding",
             $time, CYCLE_LIMIT, sb.pending());
    $display("nearest_neighbor_downscaler_test: FAIL");
    $finish;
  end

  // Offers one source beat after an idle gap and waits for it to be taken.
  task automatic send_pixel(input src_pixel_t px, input int unsigned gap);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.blue_in  <= px.blue;
    pix.green_in <= px.green;
    pix.red_in   <= px.red;
    pix.depth_in <= px.depth;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    sb.note_source_pixel(px);
    beats_sent++;
  endtask

  // One register write beat; the caller lowers valid after the last one.
  task automatic write_register(input logic [nnds_pkg::CFG_IDX_W-1:0] idx,
                                input logic [nnds_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Stops the source stream and lets the block empty before the next write.
  task automatic finish_phase();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic src_pixel_t random_pixel();
    src_pixel_t px;
    px.blue  = nnds_pkg::COLOUR_W'($urandom);
    px.green = nnds_pkg::COLOUR_W'($urandom);
    px.red   = nnds_pkg::COLOUR_W'($urandom);
    px.depth = nnds_pkg::DEPTH_W'($urandom) >> $urandom_range(0, nnds_pkg::DEPTH_W - 1);
    return px;
  endfunction

  // Result receiver: random back-pressure, plus one long hold on request.
  initial begin
    int unsigned gap;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (res.valid !== 1'b1);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
      sb.check_output_pixel(res.red_out, res.green_out, res.blue_out, res.frame_last);
    end
  end

  // Stimulus.
  initial begin
    int unsigned                     n_items;
    int unsigned                     gap;
    int unsigned                     pause_at;
    int unsigned                     phase_num;
    int unsigned                     rand_items;
    logic [nnds_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [nnds_pkg::DIM_REG_W-1:0]  dim;
    logic [nnds_pkg::CFG_DATA_W-1:0] word;
    bit                              pressure_hold;
    bit                              pressure_pause;
    bit                              wrote_any;
    bit                              tx_idle;

    sb             = new();
    rx_idle        = 1'b0;
    hold_req       = 1'b0;
    beats_sent     = 0;
    settings_count = 0;
    phase_num      = 0;
    rand_items     = 0;

    rst_ni       <= 1'b0;
    cfg.valid    <= 1'b0;
    cfg.index    <= '0;
    cfg.data     <= '0;
    pix.valid    <= 1'b0;
    pix.blue_in  <= '0;
    pix.green_in <= '0;
    pix.red_in   <= '0;
    pix.depth_in <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: colour mode, every pixel of the first row is kept.
    send_pixel('{8'h00, 8'h00, 8'h00, 24'hFFFFFF}, 0);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 24'h000000}, 0);
    send_pixel('{8'h0F, 8'h55, 8'hAA, 24'h5A5A5A}, 0);
    send_pixel(random_pixel(), 0);
    finish_phase();

    // Small 3x2 frame in depth mode with the largest scale; saturation.
    write_register(nnds_pkg::REG_SRC_WIDTH, nnds_pkg::CFG_DATA_W'(3));
    write_register(nnds_pkg::REG_SRC_HEIGHT, nnds_pkg::CFG_DATA_W'(2));
    write_register(nnds_pkg::REG_DST_WIDTH, nnds_pkg::CFG_DATA_W'(2));
    write_register(nnds_pkg::REG_DST_HEIGHT, nnds_pkg::CFG_DATA_W'(2));
    write_register(nnds_pkg::REG_FORMAT_MODE, nnds_pkg::CFG_DATA_W'(1));
    write_register(nnds_pkg::REG_DEPTH_SCALE, '1);
    write_register(REG_SPARE_LO, '1);
    cfg.valid <= 1'b0;
    settings_count++;
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 24'h000000}, 0);
    send_pixel('{8'h00, 8'h00, 8'h00, 24'hFFFFFF}, 0);
    send_pixel('{8'h12, 8'h34, 8'h56, 24'h001000}, 0);
    send_pixel('{8'h00, 8'h00, 8'h00, 24'h010000}, 0);
    send_pixel('{8'hFF, 8'h00, 8'hFF, 24'h00FFFF}, 0);
    send_pixel('{8'h00, 8'hFF, 8'h00, 24'h000FFF}, 0);
    finish_phase();

    // Sizes below and above range are clamped; a zero scale gives black.
    write_register(nnds_pkg::REG_SRC_WIDTH, '0);
    write_register(nnds_pkg::REG_SRC_HEIGHT, nnds_pkg::CFG_DATA_W'(3));
    write_register(nnds_pkg::REG_DST_WIDTH, nnds_pkg::CFG_DATA_W'(DIM_MAX_WORD));
    write_register(nnds_pkg::REG_DST_HEIGHT, '0);
    write_register(nnds_pkg::REG_DEPTH_SCALE, '0);
    write_register(REG_SPARE_HI, nnds_pkg::CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
    settings_count++;
    repeat (4) send_pixel('{8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF}, 0);
    finish_phase();

    // Widest frame, back in colour mode.
    write_register(nnds_pkg::REG_SRC_WIDTH, nnds_pkg::CFG_DATA_W'(DIM_MAX_WORD));
    write_register(nnds_pkg::REG_SRC_HEIGHT, nnds_pkg::CFG_DATA_W'(nnds_pkg::MAX_DIM));
    write_register(nnds_pkg::REG_DST_WIDTH, nnds_pkg::CFG_DATA_W'(nnds_pkg::MAX_DIM));
    write_register(nnds_pkg::REG_DST_HEIGHT, nnds_pkg::CFG_DATA_W'(1));
    write_register(nnds_pkg::REG_FORMAT_MODE, '0);
    write_register(nnds_pkg::REG_DEPTH_SCALE, nnds_pkg::DEPTH_SCALE_RST);
    cfg.valid <= 1'b0;
    settings_count++;
    send_pixel('{8'hFF, 8'h00, 8'h00, 24'h000000}, 0);
    send_pixel('{8'h00, 8'hFF, 8'h00, 24'hFFFFFF}, 0);
    send_pixel('{8'h00, 8'h00, 8'hFF, 24'h000000}, 0);
    send_pixel('{8'hAA, 8'h55, 8'hAA, 24'hA5A5A5}, 0);
    finish_phase();

    // Random phases: a random set of register writes, then a raster stream.
    while (rand_items < RANDOM_ITEMS) begin
      pressure_hold  = (phase_num == 2);
      pressure_pause = (phase_num == 5);
      tx_idle        = !pressure_hold && ($urandom_range(0, 2) != 0);
      rx_idle        = !pressure_hold && ($urandom_range(0, 2) != 0);
      wrote_any      = 1'b0;

      for (int r = 0; r < 8; r++) begin
        reg_idx = nnds_pkg::CFG_IDX_W'(r);
        // Mostly small frames, sometimes the extremes of the size range.
        case ($urandom_range(0, 15))
          0:       dim = '0;
          1:       dim = nnds_pkg::DIM_REG_W'(1);
          2:       dim = nnds_pkg::DIM_REG_W'(nnds_pkg::MAX_DIM);
          3:       dim = DIM_MAX_WORD;
          4:       dim = nnds_pkg::DIM_REG_W'($urandom);
          default: dim = nnds_pkg::DIM_REG_W'($urandom_range(1, 12));
        endcase
        word = {(nnds_pkg::CFG_DATA_W - nnds_pkg::DIM_REG_W)'($urandom), dim};
        case (reg_idx)
          nnds_pkg::REG_FORMAT_MODE: word = nnds_pkg::CFG_DATA_W'($urandom);
          nnds_pkg::REG_DEPTH_SCALE: begin
            case ($urandom_range(0, 7))
              0:       word = '0;
              1:       word = '1;
              2:       word = nnds_pkg::DEPTH_SCALE_RST;
              default: word = nnds_pkg::CFG_DATA_W'($urandom) >>
                              $urandom_range(0, nnds_pkg::SCALE_W - 1);
            endcase
          end
          default: ;
        endcase
        if ($urandom_range(0, (reg_idx >= REG_SPARE_LO) ? 5 : 2) == 0) begin
          write_register(reg_idx, word);
          wrote_any = 1'b1;
        end
      end
      if (!wrote_any) begin
        write_register(nnds_pkg::REG_FORMAT_MODE, nnds_pkg::CFG_DATA_W'($urandom));
      end

      // Every pixel kept, so a held receiver fills the block quickly.
      if (pressure_hold) begin
        write_register(nnds_pkg::REG_SRC_WIDTH, nnds_pkg::CFG_DATA_W'(8));
        write_register(nnds_pkg::REG_SRC_HEIGHT, nnds_pkg::CFG_DATA_W'(4));
        write_register(nnds_pkg::REG_DST_WIDTH, nnds_pkg::CFG_DATA_W'(8));
        write_register(nnds_pkg::REG_DST_HEIGHT, nnds_pkg::CFG_DATA_W'(4));
      end
      cfg.valid <= 1'b0;
      settings_count++;

      n_items  = pressure_hold ? 150 : $urandom_range(20, 120);
      pause_at = pressure_pause ? n_items / 2 : n_items;
      if (pressure_hold) hold_req = 1'b1;

      for (int i = 0; i < n_items; i++) begin
        // Sender waits mid-frame until every pending pixel has come out.
        if (i == pause_at) begin
          pix.valid <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        send_pixel(random_pixel(), gap);
      end
      rand_items += n_items;
      finish_phase();
      phase_num++;
    end

    $display("Covered %0d source beats and %0d output pixels (%0d frame ends)",
             beats_sent, sb.checked_count, sb.frame_ends);
    $display("over %0d register settings, colour and depth mode, with stalls on both streams",
             settings_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("nearest_neighbor_downscaler_test: PASS");
    end else begin
      $display("%0t: %0d mismatches, %0d pixels never arrived", $time, sb.fail_count,
               sb.pending());
      $display("nearest_neighbor_downscaler_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nnds_pkg.sv
rtl/core/nnds_if.sv
rtl/core/nnds_cfg.sv
rtl/core/nnds_walk.sv
rtl/core/nnds_pipe.sv
rtl/core/nearest_neighbor_downscaler.sv
verif/nearest_neighbor_downscaler_test.sv
